>>> src/homogeneous_point_transform_macros.svh
// Assertion macros used by the checker file.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_MACROS_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define HPT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define HPT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> src/hpt_pkg.sv
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared constants and register indexes of the point transform.
// ----------------------------------------------------------------------------
package hpt_pkg;
   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int REG_WIDTH       = 32;
   localparam int CSR_ADDR_WIDTH  = 6;

   typedef enum logic [2:0] {
      REG_COEF_XX = 3'd0, REG_COEF_XY = 3'd1, REG_OFFSET_X = 3'd2,
      REG_COEF_YX = 3'd3, REG_COEF_YY = 3'd4, REG_OFFSET_Y = 3'd5,
      REG_PERSP_W = 3'd6, REG_PERSP_C = 3'd7
   } reg_index_type;

   localparam logic [31:0] RESET_ONE = 32'd65536;
endpackage

>>> src/hpt_csr.sv
// ----------------------------------------------------------------------------
// hpt_csr
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module hpt_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [hpt_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready,
   output logic [31:0] coef_ff [6],
   output logic [63:0] persp_w_ff,
   output logic [31:0] persp_c_ff
);
   import hpt_pkg::*;
   logic          wr;
   reg_index_type idx;

   assign pready = 1'b1;
   assign wr  = psel & penable & pwrite;
   assign idx = reg_index_type'(paddr[5:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[0] <= RESET_ONE; coef_ff[1] <= '0; coef_ff[2] <= '0;
         coef_ff[3] <= '0; coef_ff[4] <= RESET_ONE; coef_ff[5] <= '0;
         persp_w_ff <= '0; persp_c_ff <= RESET_ONE;
      end else if (wr && paddr[2:0] == 3'd0) begin
         case (idx)
            REG_PERSP_W: persp_w_ff <= pwdata;
            REG_PERSP_C: persp_c_ff <= pwdata[31:0];
            default:     coef_ff[idx] <= pwdata[31:0];
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_PERSP_W: prdata = persp_w_ff;
         REG_PERSP_C: prdata = {32'd0, persp_c_ff};
         default:     prdata = {32'd0, coef_ff[idx]};
      endcase
   end
endmodule

>>> src/hpt_divider.sv
// ----------------------------------------------------------------------------
// hpt_divider
// Pipelined restoring divider, one quotient bit per stage, with stall.
// ----------------------------------------------------------------------------
module hpt_divider #(
   parameter int NW = 80,   // numerator magnitude width
   parameter int DW = 66,   // divisor magnitude width
   parameter int QW = 33,   // quotient bits kept
   parameter int TW = 4     // tag width
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [TW-1:0] in_tag,
   output logic          out_valid,
   output logic [QW:0]   out_quo,   // top bit flags a quotient that overflows QW bits
   output logic [TW-1:0] out_tag
);
   // Quotient bits above QW-1 only matter as an overflow flag. When the numerator
   // bits above QW-1 are below den, they form the starting remainder and only the
   // low QW bits are shifted in; otherwise the quotient overflows QW bits.
   localparam int RW = DW + 1;
   logic [RW-1:0]   rem_ff [QW+1];
   logic [NW-1:0]   num_ff [QW+1];
   logic [DW-1:0]   den_ff [QW+1];
   logic [QW-1:0]   quo_ff [QW+1];
   logic [TW-1:0]   tag_ff [QW+1];
   logic            ovf_ff [QW+1];
   logic            vld_ff [QW+1];
   logic [NW+DW:0]  hi_part;
   logic            hi_ovf;

   // Quotient >= 2^QW exactly when num >= den << QW.
   assign hi_part = {{(DW+1){1'b0}}, in_num};
   assign hi_ovf  = (hi_part >> QW) >= {{(NW+1){1'b0}}, in_den};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= QW; i++) vld_ff[i] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i <= QW; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= RW'(in_num >> QW);
         num_ff[0] <= in_num;
         den_ff[0] <= in_den;
         quo_ff[0] <= '0;
         tag_ff[0] <= in_tag;
         ovf_ff[0] <= hi_ovf;
         for (int i = 1; i <= QW; i++) begin
            logic [RW-1:0] trial;
            logic [RW:0]   diff;
            trial = {rem_ff[i-1][RW-2:0], num_ff[i-1][QW-i]};
            diff  = {1'b0, trial} - {2'b0, den_ff[i-1]};
            rem_ff[i] <= diff[RW] ? trial : diff[RW-1:0];
            quo_ff[i] <= {quo_ff[i-1][QW-2:0], ~diff[RW]};
            num_ff[i] <= num_ff[i-1];
            den_ff[i] <= den_ff[i-1];
            tag_ff[i] <= tag_ff[i-1];
            ovf_ff[i] <= ovf_ff[i-1];
         end
      end
   end

   assign out_valid = vld_ff[QW];
   assign out_quo   = {ovf_ff[QW], quo_ff[QW]};
   assign out_tag   = tag_ff[QW];
endmodule

>>> src/homogeneous_point_transform.sv
// ----------------------------------------------------------------------------
// homogeneous_point_transform
// Maps 2D points through a programmable 3x3 projective matrix.
// ----------------------------------------------------------------------------
// Usage: send points on req_ (tdata = point_x, point_y from bit 0 up), take
// results on rsp_ (tdata = out_x, out_y; tuser = degenerate, overflow).
// Program the matrix through csr_ while no point is in flight.
// Throughput: one point per clock while no stall holds the pipe. Path from the
// request to the result: four stages for the point, the products, the
// sums and the magnitudes, then an entry register plus one stage per quotient
// bit in each divider (COORD_WIDTH+2 stages), then the output register.
// Every stage moves only when the output register is free or being taken,
// so a stalled receiver holds the whole pipe and nothing is lost or repeated;
// req_tready falls while the output is full and not taken.
// Reset clears all valid bits and loads the identity matrix.
// ----------------------------------------------------------------------------
module homogeneous_point_transform #(
   parameter int COORD_WIDTH = hpt_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = hpt_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [2*COORD_WIDTH-1:0] req_tdata,  // point_x, point_y
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [2*COORD_WIDTH-1:0] rsp_tdata,  // out_x, out_y
   output logic [1:0] rsp_tuser,                // degenerate, overflow
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [hpt_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic csr_pready
);
   import hpt_pkg::*;
   localparam int CW = COORD_WIDTH;
   localparam int PW = CW + REG_WIDTH;      // product width
   localparam int SW = PW + 2;              // sum width
   localparam int NW = SW + FRAC_BITS;      // shifted numerator magnitude
   localparam int QW = CW + 1;

   logic [31:0] coef [6];
   logic [63:0] persp_w;
   logic [31:0] persp_c;
   logic advance;

   hpt_csr u_csr (
      .clock, .reset, .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite),
      .paddr(csr_paddr), .pwdata(csr_pwdata), .prdata(csr_prdata),
      .pready(csr_pready), .coef_ff(coef), .persp_w_ff(persp_w), .persp_c_ff(persp_c)
   );

   // Advance everything when the output is empty or being taken.
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // Stage 1: register the point.
   logic v1_ff;
   logic signed [CW-1:0] px_ff, py_ff;
   // Stage 2: six products.
   logic v2_ff;
   logic signed [PW-1:0] pr_ff [6];
   logic signed [SW-1:0] c_ff [3];
   // Stage 3: sums.
   logic v3_ff;
   logic signed [SW-1:0] n_ff [3];
   // Stage 4: magnitudes and signs.
   logic v4_ff, degen4_ff;
   logic [NW-1:0] mx_ff, my_ff;
   logic [SW-1:0] mw_ff;
   logic neg_x_ff, neg_y_ff;

   logic signed [31:0] wgt [6];
   assign wgt[0] = coef[0];       assign wgt[1] = coef[1];
   assign wgt[2] = coef[3];       assign wgt[3] = coef[4];
   assign wgt[4] = persp_w[31:0]; assign wgt[5] = persp_w[63:32];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_tvalid; v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         px_ff <= req_tdata[CW-1:0];
         py_ff <= req_tdata[2*CW-1:CW];
         for (int i = 0; i < 6; i++)
            pr_ff[i] <= PW'((i % 2 == 0 ? px_ff : py_ff) * wgt[i]);
         c_ff[0] <= SW'($signed(coef[2])) <<< FRAC_BITS;
         c_ff[1] <= SW'($signed(coef[5])) <<< FRAC_BITS;
         c_ff[2] <= SW'($signed(persp_c)) <<< FRAC_BITS;
         for (int k = 0; k < 3; k++)
            n_ff[k] <= SW'(pr_ff[2*k]) + SW'(pr_ff[2*k+1]) + c_ff[k];
         // order of n_ff: x, y, w
         degen4_ff <= n_ff[2] == '0;
         mx_ff <= NW'(n_ff[0][SW-1] ? -n_ff[0] : n_ff[0]) << FRAC_BITS;
         my_ff <= NW'(n_ff[1][SW-1] ? -n_ff[1] : n_ff[1]) << FRAC_BITS;
         mw_ff <= n_ff[2][SW-1] ? -n_ff[2] : n_ff[2];
         neg_x_ff <= n_ff[0][SW-1] ^ n_ff[2][SW-1];
         neg_y_ff <= n_ff[1][SW-1] ^ n_ff[2][SW-1];
      end
   end

   logic dvx, dvy;
   logic [QW:0] qx, qy;
   logic [2:0] tagx, tagy;

   hpt_divider #(.NW(NW), .DW(SW), .QW(QW), .TW(3)) u_div_x (
      .clock, .reset, .advance, .in_valid(v4_ff), .in_num(mx_ff),
      .in_den(degen4_ff ? SW'(1) : mw_ff), .in_tag({degen4_ff, neg_y_ff, neg_x_ff}),
      .out_valid(dvx), .out_quo(qx), .out_tag(tagx)
   );
   hpt_divider #(.NW(NW), .DW(SW), .QW(QW), .TW(3)) u_div_y (
      .clock, .reset, .advance, .in_valid(v4_ff), .in_num(my_ff),
      .in_den(degen4_ff ? SW'(1) : mw_ff), .in_tag({degen4_ff, neg_y_ff, neg_x_ff}),
      .out_valid(dvy), .out_quo(qy), .out_tag(tagy)
   );

   // Saturate a magnitude and apply the sign.
   function automatic logic [CW:0] sat(input logic [QW:0] q, input logic neg);
      logic [QW:0] lim;
      logic [CW-1:0] m;
      logic o;
      lim = neg ? (QW+1)'(1) << (CW-1) : ((QW+1)'(1) << (CW-1)) - 1'b1;
      o = q > lim;
      m = o ? lim[CW-1:0] : q[CW-1:0];
      return {o, neg ? -m : m};
   endfunction

   logic [CW:0] sx, sy;
   assign sx = sat(qx, tagx[0]);
   assign sy = sat(qy, tagx[1]);

   always_ff @(posedge clock) begin
      if (reset) rsp_tvalid <= 1'b0;
      else if (advance) rsp_tvalid <= dvx & dvy;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (tagx[2]) begin
            rsp_tdata <= '0;
            rsp_tuser <= 2'b01;
         end else begin
            rsp_tdata <= {sy[CW-1:0], sx[CW-1:0]};
            rsp_tuser <= {sx[CW] | sy[CW], 1'b0};
         end
      end
   end

   logic unused_tag;
   assign unused_tag = ^tagy;
endmodule

>>> src/hpt_checker.sv
// ----------------------------------------------------------------------------
// hpt_checker
// Port-level checks of the point transform, bound to the top level.
// ----------------------------------------------------------------------------
`include "homogeneous_point_transform_macros.svh"
module hpt_checker (
   input logic clock,
   input logic reset,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [1:0] rsp_tuser,
   input logic csr_pready
);
   `HPT_ASSERT_IMPL(a_ready_follows_out, clock, reset, rsp_tvalid && !rsp_tready, !req_tready, "ready high while output stalled")
   `HPT_ASSERT_IMPL(a_flags_excl, clock, reset, rsp_tvalid, !(rsp_tuser[0] && rsp_tuser[1]), "degenerate with overflow")
   `HPT_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tuser), "stalled result changed")
   `HPT_ASSERT_IMPL(a_pready, clock, reset, 1'b1, csr_pready, "pready low")
endmodule

bind homogeneous_point_transform hpt_checker u_hpt_checker (
   .clock, .reset, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tuser, .csr_pready
);

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the projective point transform: points stream in
// with bursty gaps, results drain against random stalls, and each result is
// checked against an in-bench fixed-point predictor of the 3x3 mapping.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import hpt_pkg::*;

   localparam int CW = 32;
   localparam int FB = 16;
   localparam int LATENCY = CW + 12;

   typedef struct packed {
      logic [CW-1:0] out_x;
      logic [CW-1:0] out_y;
      logic          degenerate;
      logic          overflow;
   } point_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [2*CW-1:0] req_tdata = '0;  // point_x, point_y
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [2*CW-1:0] rsp_tdata;       // out_x, out_y
   logic [1:0] rsp_tuser;            // degenerate, overflow
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic csr_pready;

   homogeneous_point_transform u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the matrix registers.
   logic signed [31:0] m_xx, m_xy, m_ox, m_yx, m_yy, m_oy, m_wx, m_wy, m_wc;

   point_result_type expected_results[$];
   int  failures = 0;
   bit  stall_enable = 1'b1;
   int  burst_left = 0;

   // Truncating divide of num * 2^FB by w, saturated to CW bits.
   function automatic logic [CW-1:0] divide_saturate(logic signed [127:0] num,
                                                     logic signed [127:0] w,
                                                     inout logic ovf);
      logic neg;
      logic [127:0] an, aw, q, lim;
      neg = num[127] ^ w[127];
      an  = num[127] ? -num : num;
      aw  = w[127] ? -w : w;
      q   = (an << FB) / aw;
      lim = neg ? (128'd1 << (CW-1)) : ((128'd1 << (CW-1)) - 1);
      if (q > lim) begin
         q = lim;
         ovf = 1'b1;
      end
      return neg ? -q[CW-1:0] : q[CW-1:0];
   endfunction

   function automatic point_result_type project_point(logic signed [31:0] px,
                                                      logic signed [31:0] py);
      logic signed [127:0] w, nx, ny;
      point_result_type r;
      logic ovf;
      w  = 128'(px) * 128'(m_wx) + 128'(py) * 128'(m_wy) + (128'(m_wc) <<< FB);
      nx = 128'(px) * 128'(m_xx) + 128'(py) * 128'(m_xy) + (128'(m_ox) <<< FB);
      ny = 128'(px) * 128'(m_yx) + 128'(py) * 128'(m_yy) + (128'(m_oy) <<< FB);
      r = '0;
      ovf = 1'b0;
      if (w == 0) begin
         r.degenerate = 1'b1;
      end else begin
         r.out_x = divide_saturate(nx, w, ovf);
         r.out_y = divide_saturate(ny, w, ovf);
         r.overflow = ovf;
      end
      return r;
   endfunction

   // Write one register once every request in flight has come back.
   task automatic write_register(reg_index_type idx, logic [63:0] value);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_WIDTH'(8 * idx);
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_COEF_XX:  m_xx = value[31:0];
         REG_COEF_XY:  m_xy = value[31:0];
         REG_OFFSET_X: m_ox = value[31:0];
         REG_COEF_YX:  m_yx = value[31:0];
         REG_COEF_YY:  m_yy = value[31:0];
         REG_OFFSET_Y: m_oy = value[31:0];
         REG_PERSP_W: begin
            m_wx = value[31:0];
            m_wy = value[63:32];
         end
         default:      m_wc = value[31:0];
      endcase
   endtask

   // Send one request; gaps come between bursts of random length.
   task automatic send_point(logic [31:0] px, logic [31:0] py);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = stall_enable ? $urandom_range(0, 6) : 0;
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {py, px};
      expected_results.push_back(project_point(px, py));
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Wait until every expected result has come back, then let the pipe settle.
   task automatic drain;
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0 && guard < 100000) begin
         @(negedge clock);
         guard++;
      end
      repeat (LATENCY) @(negedge clock);
   endtask

   function automatic logic [31:0] random_coord();
      case ($urandom_range(0, 5))
         0:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         1:       return 32'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
         2:       return 32'($signed($urandom_range(0, 2048 << FB)) - (1024 << FB));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] random_coef();
      case ($urandom_range(0, 5))
         0:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         1:       return 32'($signed($urandom_range(0, 4 << FB)) - (2 << FB));
         2:       return $urandom_range(0, 1) ? 32'd0 : 32'($signed($urandom_range(0, 255)) - 128);
         default: return $urandom;
      endcase
   endfunction

   // Check results as they are accepted.
   always @(posedge clock) begin
      point_result_type got, exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.out_x      = rsp_tdata[CW-1:0];
         got.out_y      = rsp_tdata[2*CW-1:CW];
         got.degenerate = rsp_tuser[0];
         got.overflow   = rsp_tuser[1];
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            failures++;
         end else begin
            exp_r = expected_results.pop_front();
            if (got !== exp_r) begin
               $display("%0t: result mismatch expected x=%h y=%h deg=%b ovf=%b",
                        $time, exp_r.out_x, exp_r.out_y, exp_r.degenerate, exp_r.overflow);
               $display("%0t:                  actual x=%h y=%h deg=%b ovf=%b",
                        $time, got.out_x, got.out_y, got.degenerate, got.overflow);
               failures++;
            end
         end
      end
   end

   // Receiver stalls on its own pattern, with stall-free stretches.
   always @(negedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else if (!stall_enable)
         rsp_tready <= 1'b1;
      else
         rsp_tready <= ($urandom_range(0, 99) < 65);
   end

   task automatic test_identity;
      send_point(32'h00010000, 32'h00020000);
      send_point(32'h7fffffff, 32'h80000000);
      send_point(32'h80000000, 32'h7fffffff);
      send_point(32'hffffffff, 32'h00000000);
      send_point(32'h00000000, 32'h00000001);
      drain();
   endtask

   task automatic test_degenerate;
      write_register(REG_PERSP_C, 64'd0);
      send_point(32'h00000000, 32'h00000000);
      write_register(REG_PERSP_W, {32'h00010000, 32'h00010000});
      write_register(REG_PERSP_C, 64'd0);
      send_point(32'h00010000, 32'hffff0000);  // w exactly zero
      send_point(32'h00020000, 32'h00010000);
      drain();
   endtask

   task automatic test_overflow;
      write_register(REG_PERSP_W, 64'd0);
      write_register(REG_PERSP_C, 64'd1);       // tiny divisor
      write_register(REG_COEF_XX, 64'h7fffffff);
      write_register(REG_COEF_XY, 64'h80000000);
      write_register(REG_OFFSET_X, 64'h7fffffff);
      write_register(REG_COEF_YX, 64'h80000000);
      write_register(REG_COEF_YY, 64'h7fffffff);
      write_register(REG_OFFSET_Y, 64'h80000000);
      send_point(32'h7fffffff, 32'h7fffffff);
      send_point(32'h80000000, 32'h80000000);
      send_point(32'h00000000, 32'h00000000);
      write_register(REG_PERSP_C, 64'hffffffff);  // negative divisor, rounding sign
      send_point(32'h00000001, 32'h00000000);
      send_point(32'hffffffff, 32'h00000003);
      write_register(REG_PERSP_C, 64'h80000000);
      send_point(32'h00000003, 32'hfffffffd);
      send_point(32'h80000000, 32'h7fffffff);
      drain();
   endtask

   task automatic test_random_points;
      for (int phase = 0; phase < 16; phase++) begin
         stall_enable = (phase % 4 != 3);
         if (phase == 15) begin
            write_register(REG_COEF_XX, 64'h00010000);
            write_register(REG_COEF_XY, 64'd0);
            write_register(REG_OFFSET_X, 64'd0);
            write_register(REG_COEF_YX, 64'd0);
            write_register(REG_COEF_YY, 64'h00010000);
            write_register(REG_OFFSET_Y, 64'd0);
            write_register(REG_PERSP_W, 64'd0);
            write_register(REG_PERSP_C, 64'h00010000);
         end else begin
            write_register(REG_COEF_XX, random_coef());
            write_register(REG_COEF_XY, random_coef());
            write_register(REG_OFFSET_X, random_coef());
            write_register(REG_COEF_YX, random_coef());
            write_register(REG_COEF_YY, random_coef());
            write_register(REG_OFFSET_Y, random_coef());
            write_register(REG_PERSP_W, {random_coef(), random_coef()});
            write_register(REG_PERSP_C, random_coef());
         end
         for (int i = 0; i < 100; i++)
            send_point(random_coord(), random_coord());
         drain();
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      m_xx = RESET_ONE; m_xy = 0; m_ox = 0;
      m_yx = 0; m_yy = RESET_ONE; m_oy = 0;
      m_wx = 0; m_wy = 0; m_wc = RESET_ONE;
      test_identity();
      test_degenerate();
      test_overflow();
      test_random_points();
      if (failures == 0 && expected_results.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Hold a generous cap on the whole run.
   initial begin
      #5ms;
      $display("FAIL");
      $finish;
   end
endmodule

>>> filelist.f
+incdir+src
src/hpt_pkg.sv
src/hpt_csr.sv
src/hpt_divider.sv
src/homogeneous_point_transform.sv
src/hpt_checker.sv
test/testbench.sv
